// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for concurrent checks, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg)
`define ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// File: design/qsu_pkg.sv
// ---------------------------------------------------------------------------
// qsu_pkg
// Types, constants and tables shared by the slerp pipeline
// ---------------------------------------------------------------------------
package qsu_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ROOT_STEPS   = 18;
  localparam int QUOT_BITS    = 20;

  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [31:0] GAIN_Q24    = 32'sd10188014;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [15:0] LIMIT_RESET = 16'd4;
  localparam logic [15:0] CHORD_MAX   = 16'd32768;
  localparam logic [35:0] ROOT_ONE    = 36'd1073741824;
  localparam logic [QUOT_BITS-1:0] WEIGHT_MAX = '1;

  localparam logic signed [31:0] ATAN_Q24 [CORDIC_STEPS] = '{
    32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331,
    32'sd1047214,  32'sd524117,  32'sd262123,  32'sd131069,
    32'sd65536,    32'sd32768,   32'sd16384,   32'sd8192,
    32'sd4096,     32'sd2048,    32'sd1024,    32'sd512,
    32'sd256,      32'sd128,     32'sd64,      32'sd32,
    32'sd16,       32'sd8,       32'sd4,       32'sd2
  };

  typedef struct packed {
    logic signed [15:0] start_w;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_w;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic [16:0]        fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_item_t;

  // per-item context that rides along the whole pipeline, index 0 is w
  typedef struct packed {
    logic [3:0][15:0] p;
    logic [3:0][15:0] q;
    logic [16:0]      alpha;
    logic             neg;
    logic             bypass;
    logic             linear;
    logic [15:0]      chord;
  } ctx_t;

endpackage

// File: design/qsu_front.sv
// ---------------------------------------------------------------------------
// qsu_front
// Dot product, sign choice and squared chord length, four stages
// ---------------------------------------------------------------------------
module qsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qsu_pkg::in_item_t  in_item,
  output logic               out_valid,
  output qsu_pkg::ctx_t      out_ctx,
  output logic [35:0]        sum_sq
);

  logic               vld [4];
  qsu_pkg::ctx_t      ctx_in, ctx1, ctx1_sgn, ctx2, ctx3, ctx4;
  logic signed [31:0] prod [4];
  logic signed [33:0] dot;
  logic signed [17:0] diff [4];
  logic [35:0]        sq [4];
  logic [35:0]        sum4;

  always_comb begin
    ctx_in        = '0;
    ctx_in.p      = {in_item.start_z, in_item.start_y, in_item.start_x, in_item.start_w};
    ctx_in.q      = {in_item.end_z, in_item.end_y, in_item.end_x, in_item.end_w};
    ctx_in.alpha  = in_item.fraction;
    ctx_in.bypass = in_item.fraction >= qsu_pkg::ONE_Q16;
  end

  assign dot = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);

  always_comb begin
    ctx1_sgn     = ctx1;
    ctx1_sgn.neg = dot[33];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (ctx2.neg) begin
        diff[i] = -18'($signed(ctx2.p[i])) - 18'($signed(ctx2.q[i]));
      end else begin
        diff[i] = 18'($signed(ctx2.p[i])) - 18'($signed(ctx2.q[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < 4; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1 <= ctx_in;
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(ctx_in.p[i]) * $signed(ctx_in.q[i]);
      end
      ctx2 <= ctx1_sgn;
      ctx3 <= ctx2;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= 36'(diff[i] * diff[i]);
      end
      ctx4 <= ctx3;
      sum4 <= sq[0] + sq[1] + sq[2] + sq[3];
    end
  end

  assign out_valid = vld[3];
  assign out_ctx   = ctx4;
  assign sum_sq    = sum4;

endmodule

// File: design/qsu_isqrt.sv
// ---------------------------------------------------------------------------
// qsu_isqrt
// Pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
module qsu_isqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  qsu_pkg::ctx_t  in_ctx,
  input  logic [35:0]    radicand,
  output logic           out_valid,
  output qsu_pkg::ctx_t  out_ctx,
  output logic [17:0]    root
);

  localparam int N = qsu_pkg::ROOT_STEPS;

  logic          vld_r [N];
  qsu_pkg::ctx_t ctx_r [N];
  logic [35:0]   rem_r [N];
  logic [35:0]   acc_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          vi;
    qsu_pkg::ctx_t ci;
    logic [35:0]   rem_i, acc_i, bit_k, trial;

    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign ci    = in_ctx;
      assign rem_i = radicand;
      assign acc_i = '0;
    end else begin : g_next
      assign vi    = vld_r[k-1];
      assign ci    = ctx_r[k-1];
      assign rem_i = rem_r[k-1];
      assign acc_i = acc_r[k-1];
    end

    assign bit_k = 36'd1 << (2 * (N - 1 - k));
    assign trial = acc_i + bit_k;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ci;
        if (rem_i >= trial) begin
          rem_r[k] <= rem_i - trial;
          acc_r[k] <= (acc_i >> 1) + bit_k;
        end else begin
          rem_r[k] <= rem_i;
          acc_r[k] <= acc_i >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_ctx   = ctx_r[N-1];
  assign root      = acc_r[N-1][17:0];

endmodule

// File: design/qsu_cordic.sv
// ---------------------------------------------------------------------------
// qsu_cordic
// Pipelined CORDIC, vectoring or rotation, one micro-rotation per stage
// ---------------------------------------------------------------------------
module qsu_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vectoring,
  input  logic               in_valid,
  input  qsu_pkg::ctx_t      in_ctx,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output logic               out_valid,
  output qsu_pkg::ctx_t      out_ctx,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out
);

  localparam int N = qsu_pkg::CORDIC_STEPS;

  logic               vld_r [N];
  qsu_pkg::ctx_t      ctx_r [N];
  logic signed [31:0] x_r [N];
  logic signed [31:0] y_r [N];
  logic signed [31:0] z_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic               vi;
    qsu_pkg::ctx_t      ci;
    logic signed [31:0] xi, yi, zi, xs, ys;
    logic               turn_pos;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ci = in_ctx;
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign vi = vld_r[k-1];
      assign ci = ctx_r[k-1];
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
    end

    assign xs = xi >>> k;
    assign ys = yi >>> k;
    // vectoring drives y toward zero, rotation drives z toward zero
    assign turn_pos = vectoring ? yi[31] : !zi[31];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ci;
        if (turn_pos) begin
          x_r[k] <= xi - ys;
          y_r[k] <= yi + xs;
          z_r[k] <= zi - qsu_pkg::ATAN_Q24[k];
        end else begin
          x_r[k] <= xi + ys;
          y_r[k] <= yi - xs;
          z_r[k] <= zi + qsu_pkg::ATAN_Q24[k];
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_ctx   = ctx_r[N-1];
  assign y_out     = y_r[N-1];
  assign z_out     = z_r[N-1];

endmodule

// File: design/qsu_divider.sv
// ---------------------------------------------------------------------------
// qsu_divider
// Pipelined restoring divide of part * 2^16 by whole, clamped weight
// ---------------------------------------------------------------------------
module qsu_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  qsu_pkg::ctx_t                 in_ctx,
  input  logic [24:0]                   part,
  input  logic [24:0]                   whole,
  output logic                          out_valid,
  output qsu_pkg::ctx_t                 out_ctx,
  output logic [qsu_pkg::QUOT_BITS-1:0] quotient
);

  localparam int N = qsu_pkg::QUOT_BITS;

  logic          vld_r [N];
  qsu_pkg::ctx_t ctx_r [N];
  logic [47:0]   rem_r [N];
  logic [24:0]   div_r [N];
  logic [N-1:0]  quo_r [N];
  logic          ovf_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          vi, ovf_i;
    qsu_pkg::ctx_t ci;
    logic [47:0]   rem_i, shifted;
    logic [24:0]   div_i;
    logic [N-1:0]  quo_i, bit_q;

    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign ci    = in_ctx;
      assign rem_i = {7'd0, part, 16'd0};
      assign div_i = whole;
      assign quo_i = '0;
      // quotient would exceed the weight limit
      assign ovf_i = {4'd0, part} >= {whole, 4'd0};
    end else begin : g_next
      assign vi    = vld_r[k-1];
      assign ci    = ctx_r[k-1];
      assign rem_i = rem_r[k-1];
      assign div_i = div_r[k-1];
      assign quo_i = quo_r[k-1];
      assign ovf_i = ovf_r[k-1];
    end

    assign shifted = 48'(div_i) << (N - 1 - k);
    assign bit_q   = {{(N-1){1'b0}}, 1'b1} << (N - 1 - k);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ci;
        div_r[k] <= div_i;
        ovf_r[k] <= ovf_i;
        if (rem_i >= shifted) begin
          rem_r[k] <= rem_i - shifted;
          quo_r[k] <= quo_i | bit_q;
        end else begin
          rem_r[k] <= rem_i;
          quo_r[k] <= quo_i;
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_ctx   = ctx_r[N-1];
  assign quotient  = ovf_r[N-1] ? qsu_pkg::WEIGHT_MAX : quo_r[N-1];

endmodule

// File: design/qsu_mix.sv
// ---------------------------------------------------------------------------
// qsu_mix
// Weight selection, weighted sum, rounding and saturation, two stages
// ---------------------------------------------------------------------------
module qsu_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  qsu_pkg::ctx_t                 in_ctx,
  input  logic [qsu_pkg::QUOT_BITS-1:0] w0_div,
  input  logic [qsu_pkg::QUOT_BITS-1:0] w1_div,
  output logic                          out_valid,
  output qsu_pkg::out_item_t            out_item
);

  logic               vld1;
  qsu_pkg::ctx_t      ctx1;
  logic [16:0]        w0_lin;
  logic signed [21:0] w0, w1_mag, w1;
  logic signed [37:0] pa [4];
  logic signed [37:0] pb [4];
  logic signed [15:0] res [4];
  qsu_pkg::out_item_t item_next;

  assign w0_lin = qsu_pkg::ONE_Q16 - in_ctx.alpha;

  always_comb begin
    if (in_ctx.linear) begin
      w0     = $signed({5'd0, w0_lin});
      w1_mag = $signed({5'd0, in_ctx.alpha});
    end else begin
      w0     = $signed({2'd0, w0_div});
      w1_mag = $signed({2'd0, w1_div});
    end
    // shorter arc: end quaternion enters negated
    w1 = in_ctx.neg ? -w1_mag : w1_mag;
  end

  always_comb begin
    logic signed [39:0] v;
    logic signed [39:0] r;
    for (int i = 0; i < 4; i++) begin
      v = 40'(pa[i]) + 40'(pb[i]) + 40'sd32768;
      r = v >>> 16;
      if (r > 40'sd32767) begin
        res[i] = 16'sh7FFF;
      end else if (r < -40'sd32768) begin
        res[i] = 16'sh8000;
      end else begin
        res[i] = r[15:0];
      end
    end
    if (ctx1.bypass) begin
      item_next.out_w = $signed(ctx1.q[0]);
      item_next.out_x = $signed(ctx1.q[1]);
      item_next.out_y = $signed(ctx1.q[2]);
      item_next.out_z = $signed(ctx1.q[3]);
    end else begin
      item_next.out_w = res[0];
      item_next.out_x = res[1];
      item_next.out_y = res[2];
      item_next.out_z = res[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1 <= in_ctx;
      for (int i = 0; i < 4; i++) begin
        pa[i] <= w0 * $signed(in_ctx.p[i]);
        pb[i] <= w1 * $signed(in_ctx.q[i]);
      end
      out_item <= item_next;
    end
  end

endmodule

// File: design/quaternion_slerp_unit_core.sv
// ---------------------------------------------------------------------------
// quaternion_slerp_unit_core
// Fixed-point quaternion slerp, fully pipelined, when not stalled one item per cycle
// ---------------------------------------------------------------------------
//  channel  signals                      dir  moves
//  in       in_valid in_stall in_item    in   start, end quaternion, fraction
//  out      out_valid out_stall out_item out  interpolated quaternion
//  cfg      cfg_valid cfg_ready cfg_data in   small angle limit
//
//  one item enters per cycle while not stalled, stages: 4 front, 18 + 18 square
//  root bits, 24 + 24 cordic steps, 20 quotient bits, 5 glue and mix stages
//  rst is synchronous, clears all valid bits and loads the limit with 4
//  a stalled output freezes the whole pipeline, in_stall follows it
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_slerp_unit_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qsu_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output qsu_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic                          en;
  logic [15:0]                   limit;

  logic                          f_valid, r1_valid, m1_valid, r2_valid, v_valid;
  logic                          t1_valid, t2_valid, s_valid, d_valid;
  qsu_pkg::ctx_t                 f_ctx, r1_ctx, m1_ctx, r2_ctx, v_ctx;
  qsu_pkg::ctx_t                 t1_ctx, t2_ctx, s_ctx, div_ctx, d_ctx;
  qsu_pkg::ctx_t                 r1_chord_ctx, t1_lin_ctx;
  logic [35:0]                   f_sum, rad2;
  logic [17:0]                   r1_root, r2_root;
  logic [15:0]                   s_clamp;
  logic [30:0]                   m1_ssq;
  logic signed [31:0]            vec_x, vec_y, v_z, zc;
  logic [25:0]                   t1_theta, t2_theta, t2_phi0, t2_phi1;
  logic [16:0]                   w0_lin;
  logic [42:0]                   prod0, prod1;
  logic                          near_zero;
  logic signed [31:0]            rot_y [3];
  logic [24:0]                   sin_t, sin0, sin1;
  logic [qsu_pkg::QUOT_BITS-1:0] d_w0, d_w1;

  function automatic logic signed [31:0] fold_angle(input logic [25:0] ang);
    logic signed [31:0] a32;
    a32 = $signed({6'd0, ang});
    return (a32 > qsu_pkg::HALF_PI_Q24) ? qsu_pkg::PI_Q24 - a32 : a32;
  endfunction

  function automatic logic [24:0] sin_clip(input logic signed [31:0] y);
    return y[31] ? 25'd0 : y[24:0];
  endfunction

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= qsu_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  qsu_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_item(in_item),
    .out_valid(f_valid), .out_ctx(f_ctx), .sum_sq(f_sum)
  );

  qsu_isqrt u_chord_root (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .in_ctx(f_ctx), .radicand(f_sum),
    .out_valid(r1_valid), .out_ctx(r1_ctx), .root(r1_root)
  );

  // half chord as sine, clamped to one
  assign s_clamp = (r1_root > 18'(qsu_pkg::CHORD_MAX)) ? qsu_pkg::CHORD_MAX : r1_root[15:0];

  always_comb begin
    r1_chord_ctx       = r1_ctx;
    r1_chord_ctx.chord = s_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctx <= r1_chord_ctx;
      m1_ssq <= 31'(s_clamp * s_clamp);
    end
  end

  assign rad2 = qsu_pkg::ROOT_ONE - 36'(m1_ssq);

  qsu_isqrt u_cos_root (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(m1_valid), .in_ctx(m1_ctx), .radicand(rad2),
    .out_valid(r2_valid), .out_ctx(r2_ctx), .root(r2_root)
  );

  // cosine reaches 32768 for a zero chord
  assign vec_x = $signed({6'd0, r2_root[16:0], 9'd0});
  assign vec_y = $signed({7'd0, r2_ctx.chord, 9'd0});

  qsu_cordic u_asin (
    .clk(clk), .rst(rst), .en(en), .vectoring(1'b1),
    .in_valid(r2_valid), .in_ctx(r2_ctx),
    .x_in(vec_x), .y_in(vec_y), .z_in(32'sd0),
    .out_valid(v_valid), .out_ctx(v_ctx), .y_out(), .z_out(v_z)
  );

  always_comb begin
    if (v_z < 32'sd0) begin
      zc = 32'sd0;
    end else if (v_z > qsu_pkg::HALF_PI_Q24) begin
      zc = qsu_pkg::HALF_PI_Q24;
    end else begin
      zc = v_z;
    end
  end

  assign w0_lin    = qsu_pkg::ONE_Q16 - t1_ctx.alpha;
  assign prod0     = 43'(w0_lin) * 43'(t1_theta);
  assign prod1     = 43'(t1_ctx.alpha) * 43'(t1_theta);
  assign near_zero = t1_theta < {2'd0, limit, 8'd0};

  always_comb begin
    t1_lin_ctx        = t1_ctx;
    t1_lin_ctx.linear = near_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
    end else if (en) begin
      t1_valid <= v_valid;
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_ctx   <= v_ctx;
      t1_theta <= {zc[24:0], 1'b0};
      t2_ctx   <= t1_lin_ctx;
      t2_theta <= t1_theta;
      t2_phi0  <= prod0[41:16];
      t2_phi1  <= prod1[41:16];
    end
  end

  qsu_cordic u_sin_theta (
    .clk(clk), .rst(rst), .en(en), .vectoring(1'b0),
    .in_valid(t2_valid), .in_ctx(t2_ctx),
    .x_in(qsu_pkg::GAIN_Q24), .y_in(32'sd0), .z_in(fold_angle(t2_theta)),
    .out_valid(s_valid), .out_ctx(s_ctx), .y_out(rot_y[0]), .z_out()
  );

  qsu_cordic u_sin_start (
    .clk(clk), .rst(rst), .en(en), .vectoring(1'b0),
    .in_valid(t2_valid), .in_ctx(t2_ctx),
    .x_in(qsu_pkg::GAIN_Q24), .y_in(32'sd0), .z_in(fold_angle(t2_phi0)),
    .out_valid(), .out_ctx(), .y_out(rot_y[1]), .z_out()
  );

  qsu_cordic u_sin_end (
    .clk(clk), .rst(rst), .en(en), .vectoring(1'b0),
    .in_valid(t2_valid), .in_ctx(t2_ctx),
    .x_in(qsu_pkg::GAIN_Q24), .y_in(32'sd0), .z_in(fold_angle(t2_phi1)),
    .out_valid(), .out_ctx(), .y_out(rot_y[2]), .z_out()
  );

  assign sin_t = sin_clip(rot_y[0]);
  assign sin0  = sin_clip(rot_y[1]);
  assign sin1  = sin_clip(rot_y[2]);

  // zero sine falls back to linear weights
  always_comb begin
    div_ctx        = s_ctx;
    div_ctx.linear = s_ctx.linear | (sin_t == 25'd0);
  end

  qsu_divider u_div_start (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_valid), .in_ctx(div_ctx), .part(sin0), .whole(sin_t),
    .out_valid(d_valid), .out_ctx(d_ctx), .quotient(d_w0)
  );

  qsu_divider u_div_end (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_valid), .in_ctx(div_ctx), .part(sin1), .whole(sin_t),
    .out_valid(), .out_ctx(), .quotient(d_w1)
  );

  qsu_mix u_mix (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d_valid), .in_ctx(d_ctx), .w0_div(d_w0), .w1_div(d_w1),
    .out_valid(out_valid), .out_item(out_item)
  );

  `ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !out_valid, "output valid right after reset")
  `ASSERT_NEXT(a_cfg_lands, clk, rst, cfg_valid && cfg_ready, limit == $past(cfg_data), "limit write lost")
  `ASSERT_NEXT(a_mid_hold, clk, rst, m1_valid && !en, m1_valid && $stable(m1_ssq), "stage moved during stall")
  `ASSERT_IMPLIES(a_theta_range, clk, rst, t1_valid, t1_theta <= 26'(qsu_pkg::PI_Q24), "angle out of range")

endmodule

// File: test/tb_quaternion_slerp_unit_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_quaternion_slerp_unit_core
// Drives start/end quaternion pairs and fractions into the slerp pipeline,
// predicts each interpolated quaternion in fixed point and compares fields
// ---------------------------------------------------------------------------
module tb_quaternion_slerp_unit_core;

  localparam int LATENCY   = 113;
  localparam int MAX_CYCLE = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  qsu_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  qsu_pkg::out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  quaternion_slerp_unit_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  qsu_pkg::in_item_t  pending_items[$];
  qsu_pkg::out_item_t expected_quats[$];
  logic [15:0] angle_limit;
  int errors;
  int cycle_count;
  bit send_gaps;
  bit recv_gaps;
  bit hold_req;
  int hold_len;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- prediction ----------------
  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint root64(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint arcsin_vec(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < qsu_pkg::CORDIC_STEPS; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += qsu_pkg::ATAN_Q24[i];
      end else begin
        x -= ys; y += xs; z -= qsu_pkg::ATAN_Q24[i];
      end
    end
    if (z < 0) z = 0;
    if (z > qsu_pkg::HALF_PI_Q24) z = qsu_pkg::HALF_PI_Q24;
    return z;
  endfunction

  function automatic longint sine_q24(longint phi);
    longint x, y, z, xs, ys;
    x = qsu_pkg::GAIN_Q24;
    y = 0;
    if (phi > qsu_pkg::HALF_PI_Q24) phi = qsu_pkg::PI_Q24 - phi;
    if (phi < 0) phi = 0;
    z = phi;
    for (int i = 0; i < qsu_pkg::CORDIC_STEPS; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= qsu_pkg::ATAN_Q24[i];
      end else begin
        x += ys; y -= xs; z += qsu_pkg::ATAN_Q24[i];
      end
    end
    return (y < 0) ? 0 : y;
  endfunction

  function automatic longint sine_ratio(longint part, longint whole);
    longint q;
    q = (part * 65536) / whole;
    return (q > longint'(qsu_pkg::WEIGHT_MAX)) ? longint'(qsu_pkg::WEIGHT_MAX) : q;
  endfunction

  function automatic logic [15:0] blend(longint w0, longint a, longint w1, longint b);
    longint v, r;
    v = w0 * a + w1 * b + 32768;
    if (v >= 0) r = v >>> 16;
    else r = -((-v + 65535) >>> 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic qsu_pkg::out_item_t slerp_predict(qsu_pkg::in_item_t it,
                                                       logic [15:0] lim);
    longint p[4], q[4], dot, sum, d, s, c, theta, a, w0, w1, sin_t;
    logic [15:0] o[4];
    bit neg;
    qsu_pkg::out_item_t r;
    p[0] = it.start_w; p[1] = it.start_x; p[2] = it.start_y; p[3] = it.start_z;
    q[0] = it.end_w;   q[1] = it.end_x;   q[2] = it.end_y;   q[3] = it.end_z;
    a = it.fraction;
    if (a >= 65536) begin
      r.out_w = it.end_w; r.out_x = it.end_x; r.out_y = it.end_y; r.out_z = it.end_z;
      return r;
    end
    dot = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) dot += p[i] * q[i];
    neg = dot < 0;
    for (int i = 0; i < 4; i++) begin
      d = neg ? -p[i] - q[i] : p[i] - q[i];
      sum += d * d;
    end
    s = root64(sum);
    if (s > 32768) s = 32768;
    c = root64((64'sd1 << 30) - s * s);
    theta = 2 * arcsin_vec(c * 512, s * 512);
    sin_t = sine_q24(theta);
    if (theta < (longint'(lim) << 8) || sin_t <= 0) begin
      w0 = 65536 - a;
      w1 = a;
    end else begin
      w0 = sine_ratio(sine_q24(((65536 - a) * theta) >>> 16), sin_t);
      w1 = sine_ratio(sine_q24((a * theta) >>> 16), sin_t);
    end
    if (neg) w1 = -w1;
    for (int i = 0; i < 4; i++) o[i] = blend(w0, p[i], w1, q[i]);
    r.out_w = o[0]; r.out_x = o[1]; r.out_y = o[2]; r.out_z = o[3];
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    errors++;
  endtask

  // input acceptance seen at the rising edge
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // driver: next item presented after acceptance, valid held low during a gap
  int send_gap;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(pending_items.pop_front());
        expected_quats.push_back(slerp_predict(in_item, angle_limit));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (in_valid && !in_taken) begin
        // hold stalled item
      end else if (send_gaps && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 19);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    qsu_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $display("unexpected item at cycle %0d", cycle_count);
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if (out_item.out_w !== want.out_w) report_mismatch("out_w", out_item.out_w, want.out_w);
        if (out_item.out_x !== want.out_x) report_mismatch("out_x", out_item.out_x, want.out_x);
        if (out_item.out_y !== want.out_y) report_mismatch("out_y", out_item.out_y, want.out_y);
        if (out_item.out_z !== want.out_z) report_mismatch("out_z", out_item.out_z, want.out_z);
      end
    end
  end

  // receiver stall bursts, plus a long hold-off on request
  int recv_gap;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req || hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_req ? 300 : hold_len - 1;
    end else begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 19);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_item(logic [15:0] sw, logic [15:0] sx, logic [15:0] sy,
                          logic [15:0] sz, logic [15:0] ew, logic [15:0] ex,
                          logic [15:0] ey, logic [15:0] ez, logic [16:0] fr);
    qsu_pkg::in_item_t it;
    it.start_w = sw; it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.end_w = ew; it.end_x = ex; it.end_y = ey; it.end_z = ez;
    it.fraction = fr;
    pending_items.push_back(it);
  endtask

  // near-unit quaternion pair with a random rotation between them
  task automatic add_unit_pair(int spread);
    real a0, a1, a2, a3, n, b0, b1, b2, b3, m;
    a0 = $urandom_range(0, 2000) - 1000.0; a1 = $urandom_range(0, 2000) - 1000.0;
    a2 = $urandom_range(0, 2000) - 1000.0; a3 = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a0 * a0 + a1 * a1 + a2 * a2 + a3 * a3) + 1e-3;
    b0 = a0 + ($urandom_range(0, 2 * spread) - spread);
    b1 = a1 + ($urandom_range(0, 2 * spread) - spread);
    b2 = a2 + ($urandom_range(0, 2 * spread) - spread);
    b3 = a3 + ($urandom_range(0, 2 * spread) - spread);
    m = $sqrt(b0 * b0 + b1 * b1 + b2 * b2 + b3 * b3) + 1e-3;
    if ($urandom_range(0, 1)) m = -m;
    add_item(16'(int'(a0 / n * 16384.0)), 16'(int'(a1 / n * 16384.0)),
             16'(int'(a2 / n * 16384.0)), 16'(int'(a3 / n * 16384.0)),
             16'(int'(b0 / m * 16384.0)), 16'(int'(b1 / m * 16384.0)),
             16'(int'(b2 / m * 16384.0)), 16'(int'(b3 / m * 16384.0)),
             ($urandom_range(0, 15) == 0) ? 17'($urandom_range(65536, 131071))
                                          : 17'($urandom_range(0, 65535)));
  endtask

  task automatic drain_all();
    while (pending_items.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    angle_limit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] limits[4];
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    angle_limit = qsu_pkg::LIMIT_RESET;
    errors = 0;
    cycle_count = 0;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_req = 1'b0;
    hold_len = 0;
    send_gap = 0;
    recv_gap = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity pair, opposite arcs, extremes, fraction edges
    add_item(16384, 0, 0, 0, 16384, 0, 0, 0, 17'd32768);
    add_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd0);
    add_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd32768);
    add_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd65535);
    add_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd65536);
    add_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'h1ffff);
    add_item(16384, 0, 0, 0, -16384, 0, 0, 0, 17'd16384);
    add_item(16384, 0, 0, 0, -11585, -11585, 0, 0, 17'd40000);
    add_item(16384, 0, 0, 0, 16383, 181, 0, 0, 17'd30000);
    add_item(16384, 0, 0, 0, 0, 0, 0, 16384, 17'd1);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
             16'h8000, 17'd20000);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
             16'h8000, 17'd50000);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
             16'h8000, 17'd65535);
    add_item(0, 0, 0, 0, 0, 0, 0, 0, 17'd12345);
    add_item(0, 0, 0, 0, 16384, 0, 0, 0, 17'd12345);
    add_item(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8193, 17'd33000);
    drain_all();

    limits = '{16'hffff, 16'd0, 16'd300, 16'd20000};
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (int k = 0; k < 130; k++) begin
        if ($urandom_range(0, 4) == 0)
          add_item(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), 17'($urandom_range(0, 131071)));
        else
          add_unit_pair(($urandom_range(0, 2) == 0) ? 4 : $urandom_range(10, 2000));
      end
      if (ph == 1) begin
        // long receiver hold-off while items keep coming
        @(negedge clk);
        hold_req <= 1'b1;
        @(negedge clk);
        hold_req <= 1'b0;
      end
      drain_all();
    end

    // last part without idling
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    write_limit(16'd4);
    for (int k = 0; k < 110; k++) add_unit_pair($urandom_range(2, 1500));
    drain_all();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
